// ===== hw/rtl/pat_pkg.sv =====
// Shared types and constants for the periodic alarm table.
`default_nettype none
package pat_pkg;

   localparam logic [1:0] CMD_ADD   = 2'd0;
   localparam logic [1:0] CMD_EVAL  = 2'd1;
   localparam logic [1:0] CMD_CHECK = 2'd2;

   localparam int         TIME_W     = 32;
   localparam int         PERIOD_W   = 16;
   localparam int         DELAY_W    = 17;
   localparam int         OUT_IDX_W  = 3;
   localparam int         OUT_MASK_W = 8;
   localparam int         REQ_W      = 56;
   localparam int         RSP_W      = 32;

   localparam logic [DELAY_W-1:0] NO_ALARM_DELAY = 17'h10000;
   localparam logic [TIME_W-1:0]  DELAY_CAP      = 32'h0001_0000;

   typedef struct packed {
      logic [DELAY_W-1:0]    next_delay;
      logic [OUT_MASK_W-1:0] fired_mask;
      logic                  add_ok;
      logic [OUT_IDX_W-1:0]  slot_index;
   } rsp_type;

   typedef struct packed {
      logic alloc;
      logic fire;
      logic clear_pend;
   } slot_ctl_type;

   typedef struct packed {
      logic               due;
      logic [TIME_W-1:0]  sum;
      logic [DELAY_W-1:0] delay;
   } step_res_type;

endpackage
`default_nettype wire

// ===== hw/rtl/periodic_alarm_table.sv =====
// Periodic alarm table top level: command sequencer, slot pass and result register.
//
// Takes one command per transfer and returns one result per command. An add or an
// evaluate walks every slot through the shared time unit, S_SCAN (due test and
// advance) and then S_MEAS (delay measure) for each slot, before S_DONE loads the
// result register. A check, a refused add and an unknown command go from the request
// transfer straight to S_DONE. The request side is ready only between commands; a
// finished result waits in the output register, and the sequencer stalls before
// loading the next one until that result has transferred.
`default_nettype none
module periodic_alarm_table import pat_pkg::*; #(
   parameter int SLOTS = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [REQ_W-1:0] req_tdata,  // cmd[1:0], now[33:2], interval[49:34]
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic      [RSP_W-1:0] rsp_tdata   // slot_index[2:0], add_ok[3],
                                             // fired_mask[11:4], next_delay[28:12]
);

   localparam int IdxW = SLOTS > 1 ? $clog2(SLOTS) : 1;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SCAN = 4'b0010,
      S_MEAS = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [IdxW-1:0]    idx_ff, idx_in;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic [DELAY_W-1:0] best_ff, best_in;
   rsp_type            res_ff, res_in;
   logic [RSP_W-1:0]   rsp_tdata_ff;
   logic               rsp_tvalid_ff;

   logic [1:0]          req_cmd;
   logic [TIME_W-1:0]   req_now;
   logic [PERIOD_W-1:0] req_interval;

   slot_ctl_type        ctl;
   logic [IdxW-1:0]     slot_idx;
   logic [SLOTS-1:0]    active;
   logic [SLOTS-1:0]    pending;
   logic [PERIOD_W-1:0] rd_period;
   logic [TIME_W-1:0]   rd_expiry;
   logic                free_found;
   logic [IdxW-1:0]     free_idx;
   logic [TIME_W-1:0]   add_a;
   logic [TIME_W-1:0]   add_b;
   step_res_type        step;
   logic [31:0]         free_idx_wide;
   logic [31:0]         pending_wide;
   logic                req_xfer;
   logic                idle;

   assign req_cmd      = req_tdata[1:0];
   assign req_now      = req_tdata[33:2];
   assign req_interval = req_tdata[49:34];

   assign idle       = (state_ff == S_IDLE);
   assign req_tready = idle;
   assign req_xfer   = req_tvalid && idle;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   assign slot_idx      = idle ? free_idx : idx_ff;
   assign add_a         = idle ? req_now : rd_expiry;
   assign add_b         = idle ? TIME_W'(req_interval) : TIME_W'(rd_period);
   assign free_idx_wide = 32'(free_idx);
   assign pending_wide  = 32'(pending);

   pat_slots #(
      .SLOTS(SLOTS)
   ) u_slots (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .idx        (slot_idx),
      .wr_period  (req_interval),
      .wr_expiry  (step.sum),
      .active     (active),
      .pending    (pending),
      .rd_period  (rd_period),
      .rd_expiry  (rd_expiry),
      .free_found (free_found),
      .free_idx   (free_idx)
   );

   pat_step u_step (
      .now    (now_ff),
      .expiry (rd_expiry),
      .add_a  (add_a),
      .add_b  (add_b),
      .res    (step)
   );

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      now_in   = now_ff;
      best_in  = best_ff;
      res_in   = res_ff;
      ctl      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               res_in   = '0;
               idx_in   = '0;
               now_in   = req_now;
               best_in  = NO_ALARM_DELAY;
               state_in = S_DONE;
               case (req_cmd)
                  CMD_ADD: begin
                     if (free_found) begin
                        ctl.alloc         = 1'b1;
                        res_in.add_ok     = 1'b1;
                        res_in.slot_index = free_idx_wide[OUT_IDX_W-1:0];
                        state_in          = S_SCAN;
                     end
                  end
                  CMD_EVAL: begin
                     state_in = S_SCAN;
                  end
                  CMD_CHECK: begin
                     ctl.clear_pend    = 1'b1;
                     res_in.fired_mask = pending_wide[OUT_MASK_W-1:0];
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            ctl.fire = active[idx_ff] && step.due;
            state_in = S_MEAS;
         end
         S_MEAS: begin
            if (active[idx_ff] && (step.delay < best_ff)) begin
               best_in = step.delay;
            end
            if (idx_ff == IdxW'(SLOTS - 1)) begin
               res_in.next_delay = (active[idx_ff] && (step.delay < best_ff)) ?
                                   step.delay : best_ff;
               state_in          = S_DONE;
            end else begin
               idx_in   = idx_ff + IdxW'(1);
               state_in = S_SCAN;
            end
         end
         S_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_DONE && (!rsp_tvalid_ff || rsp_tready)) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      now_ff  <= now_in;
      best_ff <= best_in;
      res_ff  <= res_in;
      if (state_ff == S_DONE && (!rsp_tvalid_ff || rsp_tready)) begin
         rsp_tdata_ff <= {(RSP_W - $bits(rsp_type))'(0), res_ff};
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/pat_step.sv =====
// Shared time arithmetic: expiry difference, due test, delay clamp and expiry advance.
`default_nettype none
module pat_step import pat_pkg::*; (
   input  wire logic [TIME_W-1:0] now,
   input  wire logic [TIME_W-1:0] expiry,
   input  wire logic [TIME_W-1:0] add_a,
   input  wire logic [TIME_W-1:0] add_b,
   output step_res_type           res
);

   logic [TIME_W-1:0] diff;

   always_comb begin
      diff      = expiry - now;
      res.due   = (diff == '0) || diff[TIME_W-1];
      res.sum   = add_a + add_b;
      if (res.due) begin
         res.delay = DELAY_W'(1);
      end else if (diff > DELAY_CAP) begin
         res.delay = NO_ALARM_DELAY;
      end else begin
         res.delay = diff[DELAY_W-1:0];
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/pat_slots.sv =====
// Slot storage: active and pending flags, periods, expiries and free-slot search.
`default_nettype none
module pat_slots import pat_pkg::*; #(
   parameter int SLOTS = 8
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire slot_ctl_type                            ctl,
   input  wire logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] idx,
   input  wire logic [PERIOD_W-1:0]                     wr_period,
   input  wire logic [TIME_W-1:0]                       wr_expiry,
   output logic      [SLOTS-1:0]                        active,
   output logic      [SLOTS-1:0]                        pending,
   output logic      [PERIOD_W-1:0]                     rd_period,
   output logic      [TIME_W-1:0]                       rd_expiry,
   output logic                                         free_found,
   output logic      [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] free_idx
);

   localparam int IdxW = SLOTS > 1 ? $clog2(SLOTS) : 1;

   logic [SLOTS-1:0]    active_ff;
   logic [SLOTS-1:0]    pending_ff;
   logic [PERIOD_W-1:0] period_ff [SLOTS];
   logic [TIME_W-1:0]   expiry_ff [SLOTS];

   assign active    = active_ff;
   assign pending   = pending_ff;
   assign rd_period = period_ff[idx];
   assign rd_expiry = expiry_ff[idx];

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IdxW'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= '0;
         pending_ff <= '0;
      end else begin
         if (ctl.alloc) begin
            active_ff[idx] <= 1'b1;
         end
         if (ctl.clear_pend) begin
            pending_ff <= '0;
         end
         if (ctl.alloc) begin
            pending_ff[idx] <= 1'b0;
         end else if (ctl.fire) begin
            pending_ff[idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.alloc) begin
         period_ff[idx] <= wr_period;
      end
      if (ctl.alloc || ctl.fire) begin
         expiry_ff[idx] <= wr_expiry;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/pat_checker.sv =====
// Port-level checks for the periodic alarm table and their binding to the top level.
`default_nettype none
module pat_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed or dropped while stalled");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while a command is in progress");

   a_add_has_delay: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3] |-> rsp_tdata[28:12] != 17'd0 && rsp_tdata[11:4] == 8'd0)
      else $error("accepted add without a delay");

   a_check_only_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[11:4] != 8'd0 |-> !rsp_tdata[3] && rsp_tdata[28:12] == 17'd0)
      else $error("fired mask on a result that is not a check");

   a_delay_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[28] && rsp_tdata[27:12] != 16'd0) && rsp_tdata[31:29] == 3'd0)
      else $error("delay above the no-alarm value or padding set");

endmodule

bind periodic_alarm_table pat_checker u_pat_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

// ===== dv/alarm_report_check.sv =====
// Response checker for the periodic alarm table: tracks slot state and compares every report.
`timescale 1ns / 100ps
module alarm_report_check import pat_pkg::*; #(
   parameter int SLOTS = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   input  wire logic             req_tready,
   input  wire logic [REQ_W-1:0] req_tdata,
   input  wire logic             rsp_tvalid,
   input  wire logic             rsp_tready,
   input  wire logic [RSP_W-1:0] rsp_tdata,
   output int                    fail_count,
   output int                    pending,
   output int                    refused_adds,
   output int                    fired_checks
);

   bit                  slot_live   [SLOTS];
   logic [PERIOD_W-1:0] slot_period [SLOTS];
   logic [TIME_W-1:0]   slot_due    [SLOTS];
   bit                  slot_fired  [SLOTS];
   rsp_type             alarm_reports_q[$];

   function automatic logic [DELAY_W-1:0] sweep_alarms(input logic [TIME_W-1:0] at);
      logic [DELAY_W-1:0] best;
      logic [DELAY_W-1:0] delay;
      logic signed [TIME_W-1:0] gap;
      best = NO_ALARM_DELAY;
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_live[i]) begin
            gap = slot_due[i] - at;
            if (gap <= 0) begin
               slot_fired[i] = 1'b1;
               slot_due[i]   = slot_due[i] + TIME_W'(slot_period[i]);
               gap           = slot_due[i] - at;
            end
            if (gap <= 0)
               delay = DELAY_W'(1);
            else if (gap > $signed(DELAY_CAP))
               delay = NO_ALARM_DELAY;
            else
               delay = gap[DELAY_W-1:0];
            if (delay < best)
               best = delay;
         end
      end
      return best;
   endfunction

   function automatic rsp_type predict_alarm_report(input logic [1:0]          cmd,
                                                    input logic [TIME_W-1:0]   at,
                                                    input logic [PERIOD_W-1:0] ivl);
      rsp_type report;
      bit      taken;
      report = '0;
      taken  = 1'b0;
      case (cmd)
         CMD_ADD: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (!taken && !slot_live[i]) begin
                  slot_live[i]      = 1'b1;
                  slot_period[i]    = ivl;
                  slot_due[i]       = at + TIME_W'(ivl);
                  slot_fired[i]     = 1'b0;
                  report.slot_index = OUT_IDX_W'(i);
                  report.add_ok     = 1'b1;
                  taken             = 1'b1;
               end
            end
            if (taken)
               report.next_delay = sweep_alarms(at);
            else
               refused_adds++;
         end
         CMD_EVAL: begin
            report.next_delay = sweep_alarms(at);
         end
         CMD_CHECK: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_fired[i]) begin
                  report.fired_mask[i] = 1'b1;
                  slot_fired[i]        = 1'b0;
               end
            end
            if (report.fired_mask != '0)
               fired_checks++;
         end
         default: begin
         end
      endcase
      return report;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      rsp_type got;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_live[i]   = 1'b0;
            slot_period[i] = '0;
            slot_due[i]    = '0;
            slot_fired[i]  = 1'b0;
         end
         alarm_reports_q.delete();
         fail_count   = 0;
         refused_adds = 0;
         fired_checks = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_type'(rsp_tdata[$bits(rsp_type)-1:0]);
            if (alarm_reports_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("Unexpected result transfer %h with no command outstanding",
                           rsp_tdata);
            end else begin
               want = alarm_reports_q.pop_front();
               if (got.slot_index !== want.slot_index || got.add_ok !== want.add_ok ||
                   got.fired_mask !== want.fired_mask ||
                   got.next_delay !== want.next_delay) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("Result mismatch: expected slot %0d ok %0d mask %h delay %0d,",
                              want.slot_index, want.add_ok, want.fired_mask, want.next_delay,
                              " got slot %0d ok %0d mask %h delay %0d",
                              got.slot_index, got.add_ok, got.fired_mask, got.next_delay);
               end
            end
         end
         if (req_tvalid && req_tready)
            alarm_reports_q.push_back(predict_alarm_report(req_tdata[1:0], req_tdata[33:2],
                                                           req_tdata[49:34]));
      end
      pending = alarm_reports_q.size();
   end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the periodic alarm table: clock, reset, command stimulus and verdict.
`timescale 1ns / 100ps
module tb_top;
   import pat_pkg::*;

   localparam logic [1:0] CMD_RESERVED   = 2'd3;
   localparam int         RANDOM_ITEMS   = 720;
   localparam int         HOLD_OFF_AT    = 150;
   localparam int         PAUSE_AT       = 380;
   localparam int         QUIET_AT       = 620;
   localparam int         HOLD_OFF_CYCLES = 80;
   localparam int         DRAIN_CYCLES   = 40;
   localparam int         WATCHDOG_LIMIT = 3000;

   logic             clock;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;   // cmd[1:0], now[33:2], interval[49:34]
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;        // slot_index[2:0], add_ok[3],
                                       // fired_mask[11:4], next_delay[28:12]

   int fail_count;
   int pending;
   int refused_adds;
   int fired_checks;
   int idle_cycles = 0;
   int adds_sent   = 0;
   int n_cmd[4]    = '{default: 0};
   bit quiet       = 1'b0;
   bit hold_off_go = 1'b0;

   periodic_alarm_table uut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

   alarm_report_check report_check (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .fail_count, .pending, .refused_adds, .fired_checks
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                     idle_cycles, pending);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // result side: random stalls, one long hold-off on request
   initial begin
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_off_go) begin
            rsp_tready = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_go = 1'b0;
            rsp_tready  = 1'b1;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clock);
            rsp_tready = 1'b1;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   task automatic offer_command(input logic [1:0]          cmd,
                                input logic [TIME_W-1:0]   at,
                                input logic [PERIOD_W-1:0] ivl);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap        = $urandom_range(1, 5);
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  = {6'b0, ivl, at, cmd};
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      n_cmd[cmd]++;
      if (cmd == CMD_ADD && adds_sent < 8)
         adds_sent++;
      @(negedge clock);
   endtask

   initial begin
      logic [TIME_W-1:0]   t_now;
      logic [PERIOD_W-1:0] ivl;
      logic [1:0]          cmd;
      int                  r;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty table, reserved code, wrap and cap behavior on one long period, then three more adds and the due edge
      t_now = 32'hFFFF_FF00;
      offer_command(CMD_EVAL, 32'd0, 16'd0);
      offer_command(CMD_CHECK, 32'd0, 16'd0);
      offer_command(CMD_RESERVED, 32'hFFFF_FFFF, 16'hFFFF);
      offer_command(CMD_ADD, t_now, 16'hFFFF);
      offer_command(CMD_EVAL, t_now - 32'd40, 16'd0);
      offer_command(CMD_EVAL, t_now + 32'd65535, 16'd0);
      offer_command(CMD_CHECK, t_now, 16'd0);
      offer_command(CMD_CHECK, t_now, 16'd0);
      t_now = 32'h0000_FF00;
      offer_command(CMD_ADD, t_now, 16'h5555);
      offer_command(CMD_ADD, t_now, 16'hAAAA);
      offer_command(CMD_ADD, t_now, 16'd100);
      offer_command(CMD_EVAL, t_now + 32'd100, 16'd0);
      offer_command(CMD_EVAL, t_now + 32'd99, 16'd0);
      offer_command(CMD_CHECK, t_now, 16'd0);
      t_now = t_now + 32'd100;

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == HOLD_OFF_AT)
            hold_off_go = 1'b1;
         if (i == PAUSE_AT) begin
            req_tvalid = 1'b0;
            wait (pending == 0);
            @(negedge clock);
         end
         if (i == QUIET_AT)
            quiet = 1'b1;

         r = $urandom_range(0, 99);
         if (r < 2)
            t_now += TIME_W'($urandom_range(100, 2000));
         else if (r < 5)
            t_now -= TIME_W'($urandom_range(0, 300));
         else
            t_now += TIME_W'($urandom_range(0, 12));

         r = $urandom_range(0, 99);
         if (r < 8 && adds_sent < 7) begin
            cmd = CMD_ADD;
            if ($urandom_range(0, 3) == 0)
               ivl = PERIOD_W'($urandom_range(24, 65535));
            else
               ivl = PERIOD_W'($urandom_range(24, 600));
         end else begin
            ivl = PERIOD_W'($urandom);
            if (r < 60)
               cmd = CMD_EVAL;
            else if (r < 90)
               cmd = CMD_CHECK;
            else if (r < 95)
               cmd = CMD_RESERVED;
            else
               cmd = CMD_EVAL;
         end
         offer_command(cmd, t_now, ivl);
      end

      // fill the table, zero period in the last slot, refused add, signed-compare edges
      while (adds_sent < 7)
         offer_command(CMD_ADD, t_now, 16'd200);
      offer_command(CMD_ADD, t_now, 16'd0);
      offer_command(CMD_ADD, t_now, 16'hFFFF);
      offer_command(CMD_EVAL, t_now + 32'd1, 16'd0);
      offer_command(CMD_CHECK, t_now, 16'd0);
      offer_command(CMD_EVAL, t_now + 32'h8000_0000, 16'd0);
      offer_command(CMD_EVAL, t_now + 32'h7FFF_FFFF, 16'd0);
      offer_command(CMD_CHECK, t_now, 16'd0);
      req_tvalid = 1'b0;

      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d adds (%0d refused), %0d passes, %0d checks, %0d reserved codes",
               n_cmd[CMD_ADD], refused_adds, n_cmd[CMD_EVAL], n_cmd[CMD_CHECK],
               n_cmd[CMD_RESERVED]);
      $display("Checks returning fired alarms: %0d, mismatches: %0d", fired_checks, fail_count);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== periodic_alarm_table.f =====
hw/rtl/pat_pkg.sv
hw/rtl/pat_step.sv
hw/rtl/pat_slots.sv
hw/rtl/periodic_alarm_table.sv
hw/rtl/pat_checker.sv
dv/alarm_report_check.sv
dv/tb_top.sv
